// ===== src/yuv_decimate_to_rgb565_assert.svh =====
// assertion macros shared by the submodule rtl files
`ifndef YUV_DECIMATE_TO_RGB565_ASSERT_SVH
`define YUV_DECIMATE_TO_RGB565_ASSERT_SVH

// same-cycle implication
`define YD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define YD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/yuvdec_pkg.sv =====
`default_nettype none

package yuvdec_pkg;

  localparam int COORD_BITS    = 12;
  localparam int STEP_BITS     = 4;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 12;
  localparam int RECIP_SHIFT   = 16;
  localparam int RECIP_BITS    = RECIP_SHIFT + 1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [STEP_BITS-1:0]  step_t;
  typedef logic [RECIP_BITS-1:0] recip_t;

  localparam logic [CFG_IDX_BITS-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_DST_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_X_STEP     = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_Y_STEP     = 3'd5;

  localparam int SRC_WIDTH_RESET  = 640;
  localparam int SRC_HEIGHT_RESET = 480;
  localparam int DST_WIDTH_RESET  = 320;
  localparam int DST_HEIGHT_RESET = 240;
  localparam int X_STEP_RESET     = 2;
  localparam int Y_STEP_RESET     = 2;

  localparam int LAST_X_Q = (SRC_WIDTH_RESET - 1) / X_STEP_RESET;
  localparam int LAST_Y_Q = (SRC_HEIGHT_RESET - 1) / Y_STEP_RESET;
  localparam coord_t LAST_X_RESET =
    coord_t'((LAST_X_Q < DST_WIDTH_RESET - 1) ? LAST_X_Q : DST_WIDTH_RESET - 1);
  localparam coord_t LAST_Y_RESET =
    coord_t'((LAST_Y_Q < DST_HEIGHT_RESET - 1) ? LAST_Y_Q : DST_HEIGHT_RESET - 1);

  // source sizes and steps already forced to at least one; output sizes are not
  typedef struct packed {
    coord_t src_w;
    coord_t src_h;
    coord_t dst_w;
    coord_t dst_h;
    step_t  x_step;
    step_t  y_step;
    coord_t last_x;
    coord_t last_y;
  } cfg_t;

  typedef struct packed {
    logic keep;
    logic last;
  } dec_t;

  // ceil(2^16 / step), exact quotient for 12-bit dividends
  function automatic recip_t step_recip(step_t s);
    recip_t r;
    case (s)
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13108;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9363;
      4'd8:    r = 17'd8192;
      4'd9:    r = 17'd7282;
      4'd10:   r = 17'd6554;
      4'd11:   r = 17'd5958;
      4'd12:   r = 17'd5462;
      4'd13:   r = 17'd5042;
      4'd14:   r = 17'd4682;
      4'd15:   r = 17'd4370;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/yuvdec_cfg.sv =====
`default_nettype none
`include "yuv_decimate_to_rgb565_assert.svh"

module yuvdec_cfg import yuvdec_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata,
  output cfg_t                          cfg
);

  localparam int PROD_BITS = COORD_BITS + RECIP_BITS;

  coord_t src_w_r, src_w_nxt;
  coord_t src_h_r, src_h_nxt;
  coord_t dst_w_r, dst_w_nxt;
  coord_t dst_h_r, dst_h_nxt;
  step_t  x_step_r, x_step_nxt;
  step_t  y_step_r, y_step_nxt;
  coord_t last_x_r, last_x_nxt;
  coord_t last_y_r, last_y_nxt;

  logic [PROD_BITS-1:0] prod_x, prod_y;
  coord_t               q_x, q_y;
  coord_t               dwm1, dhm1;

  function automatic coord_t norm_coord(coord_t v);
    return (v == '0) ? coord_t'(1) : v;
  endfunction

  function automatic step_t norm_step(step_t v);
    return (v == '0) ? step_t'(1) : v;
  endfunction

  always_comb begin
    src_w_nxt  = src_w_r;
    src_h_nxt  = src_h_r;
    dst_w_nxt  = dst_w_r;
    dst_h_nxt  = dst_h_r;
    x_step_nxt = x_step_r;
    y_step_nxt = y_step_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_SRC_WIDTH:  src_w_nxt  = cfg_wdata;
        REG_SRC_HEIGHT: src_h_nxt  = cfg_wdata;
        REG_DST_WIDTH:  dst_w_nxt  = cfg_wdata;
        REG_DST_HEIGHT: dst_h_nxt  = cfg_wdata;
        REG_X_STEP:     x_step_nxt = cfg_wdata[STEP_BITS-1:0];
        REG_Y_STEP:     y_step_nxt = cfg_wdata[STEP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // last kept index per axis: min((size-1)/step, dst-1)
  always_comb begin
    prod_x = PROD_BITS'(norm_coord(src_w_nxt) - coord_t'(1)) *
             PROD_BITS'(step_recip(norm_step(x_step_nxt)));
    prod_y = PROD_BITS'(norm_coord(src_h_nxt) - coord_t'(1)) *
             PROD_BITS'(step_recip(norm_step(y_step_nxt)));
    q_x    = prod_x[RECIP_SHIFT +: COORD_BITS];
    q_y    = prod_y[RECIP_SHIFT +: COORD_BITS];
    dwm1   = dst_w_nxt - coord_t'(1);
    dhm1   = dst_h_nxt - coord_t'(1);
    last_x_nxt = (q_x < dwm1) ? q_x : dwm1;
    last_y_nxt = (q_y < dhm1) ? q_y : dhm1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r  <= coord_t'(SRC_WIDTH_RESET);
      src_h_r  <= coord_t'(SRC_HEIGHT_RESET);
      dst_w_r  <= coord_t'(DST_WIDTH_RESET);
      dst_h_r  <= coord_t'(DST_HEIGHT_RESET);
      x_step_r <= step_t'(X_STEP_RESET);
      y_step_r <= step_t'(Y_STEP_RESET);
      last_x_r <= LAST_X_RESET;
      last_y_r <= LAST_Y_RESET;
    end else begin
      src_w_r  <= src_w_nxt;
      src_h_r  <= src_h_nxt;
      dst_w_r  <= dst_w_nxt;
      dst_h_r  <= dst_h_nxt;
      x_step_r <= x_step_nxt;
      y_step_r <= y_step_nxt;
      last_x_r <= last_x_nxt;
      last_y_r <= last_y_nxt;
    end
  end

  always_comb begin
    cfg.src_w  = norm_coord(src_w_r);
    cfg.src_h  = norm_coord(src_h_r);
    cfg.dst_w  = dst_w_r;
    cfg.dst_h  = dst_h_r;
    cfg.x_step = norm_step(x_step_r);
    cfg.y_step = norm_step(y_step_r);
    cfg.last_x = last_x_r;
    cfg.last_y = last_y_r;
  end

endmodule

`default_nettype wire

// ===== src/yuvdec_raster.sv =====
`default_nettype none
`include "yuv_decimate_to_rgb565_assert.svh"

module yuvdec_raster import yuvdec_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cfg_t cfg,
  input  wire logic accept,
  output dec_t      dec
);

  coord_t src_col_r, src_col_nxt;
  coord_t src_row_r, src_row_nxt;
  step_t  col_ph_r, col_ph_nxt;
  step_t  row_ph_r, row_ph_nxt;
  coord_t kept_col_r, kept_col_nxt;
  coord_t kept_row_r, kept_row_nxt;

  logic col_wrap, row_wrap, col_ph_wrap, row_ph_wrap;

  assign col_wrap    = ({1'b0, src_col_r} + 1'b1) >= {1'b0, cfg.src_w};
  assign row_wrap    = ({1'b0, src_row_r} + 1'b1) >= {1'b0, cfg.src_h};
  assign col_ph_wrap = ({1'b0, col_ph_r} + 1'b1) >= {1'b0, cfg.x_step};
  assign row_ph_wrap = ({1'b0, row_ph_r} + 1'b1) >= {1'b0, cfg.y_step};

  always_comb begin
    dec.keep = (col_ph_r == '0) && (row_ph_r == '0) &&
               (kept_col_r < cfg.dst_w) && (kept_row_r < cfg.dst_h);
    dec.last = dec.keep && (kept_col_r == cfg.last_x) && (kept_row_r == cfg.last_y);
  end

  always_comb begin
    src_col_nxt  = src_col_r;
    src_row_nxt  = src_row_r;
    col_ph_nxt   = col_ph_r;
    row_ph_nxt   = row_ph_r;
    kept_col_nxt = kept_col_r;
    kept_row_nxt = kept_row_r;
    if (accept) begin
      if (col_wrap) begin
        src_col_nxt  = '0;
        col_ph_nxt   = '0;
        kept_col_nxt = '0;
        if (row_wrap) begin
          src_row_nxt  = '0;
          row_ph_nxt   = '0;
          kept_row_nxt = '0;
        end else begin
          src_row_nxt = src_row_r + 1'b1;
          if (row_ph_wrap) begin
            row_ph_nxt   = '0;
            kept_row_nxt = kept_row_r + 1'b1;
          end else begin
            row_ph_nxt = row_ph_r + 1'b1;
          end
        end
      end else begin
        src_col_nxt = src_col_r + 1'b1;
        if (col_ph_wrap) begin
          col_ph_nxt   = '0;
          kept_col_nxt = kept_col_r + 1'b1;
        end else begin
          col_ph_nxt = col_ph_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_col_r  <= '0;
      src_row_r  <= '0;
      col_ph_r   <= '0;
      row_ph_r   <= '0;
      kept_col_r <= '0;
      kept_row_r <= '0;
    end else begin
      src_col_r  <= src_col_nxt;
      src_row_r  <= src_row_nxt;
      col_ph_r   <= col_ph_nxt;
      row_ph_r   <= row_ph_nxt;
      kept_col_r <= kept_col_nxt;
      kept_row_r <= kept_row_nxt;
    end
  end

  // end of line restarts the column side
  `YD_ASSERT_NEXT(a_col_restart, clk, rst_n, accept && col_wrap,
                  src_col_r == '0 && col_ph_r == '0 && kept_col_r == '0)
  // row side moves only at end of line
  `YD_ASSERT_NEXT(a_row_hold, clk, rst_n, accept && !col_wrap,
                  $stable(src_row_r) && $stable(kept_row_r) && $stable(row_ph_r))

endmodule

`default_nettype wire

// ===== src/yuvdec_convert.sv =====
`default_nettype none
`include "yuv_decimate_to_rgb565_assert.svh"

module yuvdec_convert import yuvdec_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_luma,
  input  wire logic [7:0]  in_chroma_blue,
  input  wire logic [7:0]  in_chroma_red,
  input  wire dec_t        dec,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_pixel565,
  output logic             out_frame_last
);

  typedef logic signed [18:0] acc_t;

  logic        s1_valid_r, s1_valid_nxt;
  logic [7:0]  s1_luma_r, s1_cb_r, s1_cr_r;
  logic        s1_last_r;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_pixel565_r, pixel_nxt;
  logic        out_frame_last_r;

  logic accept, out_free;
  acc_t c_t, d_t, e_t, r_t, g_t, b_t;
  logic [7:0] r8, g8, b8;

  function automatic logic [7:0] clamp8(acc_t t);
    logic [7:0] v;
    if (t < 0) begin
      v = 8'd0;
    end else if (t[17:16] != 2'b00) begin
      v = 8'd255;
    end else begin
      v = t[15:8];
    end
    return v;
  endfunction

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !out_free;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (accept) begin
      s1_valid_nxt = dec.keep;
    end else if (out_free) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    out_valid_nxt = out_free ? s1_valid_r : out_valid_r;
  end

  // bt.601 integer conversion, coefficients in 1/256
  always_comb begin
    c_t = $signed({11'b0, s1_luma_r}) - 19'sd16;
    d_t = $signed({11'b0, s1_cb_r}) - 19'sd128;
    e_t = $signed({11'b0, s1_cr_r}) - 19'sd128;
    r_t = 19'sd298 * c_t + 19'sd409 * e_t + 19'sd128;
    g_t = 19'sd298 * c_t - 19'sd100 * d_t - 19'sd208 * e_t + 19'sd128;
    b_t = 19'sd298 * c_t + 19'sd516 * d_t + 19'sd128;
    r8  = clamp8(r_t);
    g8  = clamp8(g_t);
    b8  = clamp8(b_t);
    pixel_nxt = {r8[7:3], g8[7:2], b8[7:3]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && dec.keep) begin
      s1_luma_r <= in_luma;
      s1_cb_r   <= in_chroma_blue;
      s1_cr_r   <= in_chroma_red;
      s1_last_r <= dec.last;
    end
    if (out_free && s1_valid_r) begin
      out_pixel565_r   <= pixel_nxt;
      out_frame_last_r <= s1_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel565   = out_pixel565_r;
  assign out_frame_last = out_frame_last_r;

  // a held beat in the input stage is never dropped
  `YD_ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_valid_r && !out_free, s1_valid_r)
  // a kept pixel always lands in the input stage
  `YD_ASSERT_NEXT(a_kept_enters, clk, rst_n, accept && dec.keep, s1_valid_r)
  // an output beat only comes from the input stage
  `YD_ASSERT_NOW(a_out_source, clk, rst_n, $rose(out_valid_r), $past(s1_valid_r))

endmodule

`default_nettype wire

// ===== src/yuv_decimate_to_rgb565.sv =====
// channel  | direction | handshake             | payload
// ---------+-----------+-----------------------+-----------------------------------
// in       | input     | in_valid / in_stall   | in_luma, in_chroma_blue, in_chroma_red
// out      | output    | out_valid / out_stall | out_pixel565, out_frame_last
// cfg      | input     | cfg_we                | cfg_index, cfg_wdata
//
// one source pixel is taken per cycle while in_stall is low
// the pixel path is an input register, the bt.601 multiply-add and the output register
// dropped pixels only advance the raster counters and cost no output slot
// synchronous active-low reset restores the default frame geometry and clears counters
// out_stall holds the output register; the input stage fills before in_stall rises
`default_nettype none

module yuv_decimate_to_rgb565 import yuvdec_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [7:0]               in_luma,
  input  wire logic [7:0]               in_chroma_blue,
  input  wire logic [7:0]               in_chroma_red,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [15:0]                   out_pixel565,
  output logic                          out_frame_last,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  cfg_t cfg;
  dec_t dec;
  logic accept;

  assign accept = in_valid && !in_stall;

  yuvdec_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  yuvdec_raster u_raster (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .accept (accept),
    .dec    (dec)
  );

  yuvdec_convert u_convert (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_luma        (in_luma),
    .in_chroma_blue (in_chroma_blue),
    .in_chroma_red  (in_chroma_red),
    .dec            (dec),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel565   (out_pixel565),
    .out_frame_last (out_frame_last)
  );

endmodule

`default_nettype wire

// ===== bench/yuv_decimate_to_rgb565_tb.sv =====
`default_nettype none

module yuv_decimate_to_rgb565_tb;
  import yuvdec_pkg::*;

  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 8;
  localparam int ERRORS_SHOWN  = 10;
  localparam int TARGET_PIXELS = 1050;
  localparam int BUSY_PERCENT  = 53;
  localparam int BOTH_PERCENT  = 28;
  localparam int MAX_COORD     = 4095;
  localparam int MAX_STEP      = 15;

  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

  localparam logic [7:0] EDGE_VALUES [8] = '{8'd0, 8'd255, 8'd16, 8'd235, 8'd128, 8'd1,
                                              8'd254, 8'd127};

  typedef enum int {
    PACE_FULL,
    PACE_SENDER_IDLE,
    PACE_RECEIVER_STALL,
    PACE_BOTH
  } pace_t;

  typedef struct {
    logic [7:0] luma;
    logic [7:0] cb;
    logic [7:0] cr;
  } yuv_pixel_t;

  typedef struct {
    logic [15:0] rgb;
    logic        frame_end;
  } rgb_result_t;

  logic                     clk            = 1'b0;
  logic                     rst_n          = 1'b0;
  logic                     in_valid       = 1'b0;
  logic [7:0]               in_luma        = '0;
  logic [7:0]               in_chroma_blue = '0;
  logic [7:0]               in_chroma_red  = '0;
  logic                     out_stall      = 1'b0;
  logic                     cfg_we         = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index      = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata      = '0;
  logic                     in_stall;
  logic                     out_valid;
  logic [15:0]              out_pixel565;
  logic                     out_frame_last;

  yuv_decimate_to_rgb565 dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_luma        (in_luma),
    .in_chroma_blue (in_chroma_blue),
    .in_chroma_red  (in_chroma_red),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel565   (out_pixel565),
    .out_frame_last (out_frame_last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow of the geometry registers and raster counters
  coord_t src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
  step_t  x_step_reg, y_step_reg;
  coord_t col_pos, row_pos, kept_col, kept_row;
  step_t  col_phase, row_phase;

  yuv_pixel_t  pixel_feed[$];
  rgb_result_t pending_rgb[$];
  pace_t       pace = PACE_FULL;
  bit          in_taken;
  int          pixels_loaded;
  int          pixels_taken;
  int          fail_count;
  int          idle_cycles;

  function automatic int channel8(int t);
    if (t < 0) return 0;
    t = t / 256;
    return (t > 255) ? 255 : t;
  endfunction

  function automatic logic [15:0] rgb565_of(yuv_pixel_t p);
    int c, d, e;
    logic [7:0] r8, g8, b8;
    c  = int'(p.luma) - 16;
    d  = int'(p.cb) - 128;
    e  = int'(p.cr) - 128;
    r8 = 8'(channel8(298 * c + 409 * e + 128));
    g8 = 8'(channel8(298 * c - 100 * d - 208 * e + 128));
    b8 = 8'(channel8(298 * c + 516 * d + 128));
    return {r8[7:3], g8[7:2], b8[7:3]};
  endfunction

  // index of the last kept position along one axis
  function automatic bit final_index(int size, int step, int dst, output int idx);
    int n;
    idx = 0;
    n = (size - 1) / step + 1;
    if (dst == 0) return 1'b0;
    if (n > dst) n = dst;
    idx = n - 1;
    return 1'b1;
  endfunction

  task automatic predict_pixel(yuv_pixel_t p);
    int sw, sh, xs, ys, lx, ly;
    bit has_x, has_y, keep;
    rgb_result_t res;
    sw = (src_w_reg == 0) ? 1 : int'(src_w_reg);
    sh = (src_h_reg == 0) ? 1 : int'(src_h_reg);
    xs = (x_step_reg == 0) ? 1 : int'(x_step_reg);
    ys = (y_step_reg == 0) ? 1 : int'(y_step_reg);
    keep = col_phase == 0 && row_phase == 0 && kept_col < dst_w_reg && kept_row < dst_h_reg;
    if (keep) begin
      has_x = final_index(sw, xs, int'(dst_w_reg), lx);
      has_y = final_index(sh, ys, int'(dst_h_reg), ly);
      res.rgb = rgb565_of(p);
      res.frame_end = has_x && has_y && int'(kept_col) == lx && int'(kept_row) == ly;
      pending_rgb.insert(pending_rgb.size(), res);
    end
    if (int'(col_pos) + 1 >= sw) begin
      col_pos   = '0;
      col_phase = '0;
      kept_col  = '0;
      if (int'(row_pos) + 1 >= sh) begin
        row_pos   = '0;
        row_phase = '0;
        kept_row  = '0;
      end else begin
        row_pos = row_pos + 1'b1;
        if (int'(row_phase) + 1 >= ys) begin
          row_phase = '0;
          kept_row  = kept_row + 1'b1;
        end else begin
          row_phase = row_phase + 1'b1;
        end
      end
    end else begin
      col_pos = col_pos + 1'b1;
      if (int'(col_phase) + 1 >= xs) begin
        col_phase = '0;
        kept_col  = kept_col + 1'b1;
      end else begin
        col_phase = col_phase + 1'b1;
      end
    end
  endtask

  task automatic note_failure(string what);
    fail_count++;
    if (fail_count <= ERRORS_SHOWN) begin
      $display("%s", what);
    end
  endtask

  always @(negedge clk) begin : drive_pixels
    yuv_pixel_t next_px;
    bit sender_idles, receiver_stalls;
    int idle_pct;
    sender_idles    = pace == PACE_SENDER_IDLE || pace == PACE_BOTH;
    receiver_stalls = pace == PACE_RECEIVER_STALL || pace == PACE_BOTH;
    idle_pct        = (pace == PACE_BOTH) ? BOTH_PERCENT : BUSY_PERCENT;
    if (rst_n && (!in_valid || in_taken)) begin
      if (pixel_feed.size() != 0 &&
          !(sender_idles && $urandom_range(99) < idle_pct)) begin
        next_px = pixel_feed.pop_front();
        in_valid       <= 1'b1;
        in_luma        <= next_px.luma;
        in_chroma_blue <= next_px.cb;
        in_chroma_red  <= next_px.cr;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= receiver_stalls && ($urandom_range(99) < idle_pct);
  end

  always @(posedge clk) begin : watch_ports
    rgb_result_t want;
    bit out_taken;
    yuv_pixel_t seen;
    in_taken  = rst_n && in_valid && !in_stall;
    out_taken = rst_n && out_valid === 1'b1 && !out_stall;
    if (out_taken) begin
      if (pending_rgb.size() == 0) begin
        note_failure($sformatf("unexpected pixel: pixel565 %h frame_last %b",
                               out_pixel565, out_frame_last));
      end else begin
        want = pending_rgb.pop_front();
        if (out_pixel565 !== want.rgb) begin
          note_failure($sformatf("pixel565 mismatch: expected %h, got %h",
                                 want.rgb, out_pixel565));
        end
        if (out_frame_last !== want.frame_end) begin
          note_failure($sformatf("frame_last mismatch: expected %b, got %b",
                                 want.frame_end, out_frame_last));
        end
      end
    end
    if (in_taken) begin
      seen.luma = in_luma;
      seen.cb   = in_chroma_blue;
      seen.cr   = in_chroma_red;
      predict_pixel(seen);
      pixels_taken++;
    end
    if (in_taken || out_taken || cfg_we) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_SRC_WIDTH:  src_w_reg  = data;
      REG_SRC_HEIGHT: src_h_reg  = data;
      REG_DST_WIDTH:  dst_w_reg  = data;
      REG_DST_HEIGHT: dst_h_reg  = data;
      REG_X_STEP:     x_step_reg = data[STEP_BITS-1:0];
      REG_Y_STEP:     y_step_reg = data[STEP_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic close_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // step value with junk in the unused upper bits
  function automatic logic [CFG_DATA_BITS-1:0] step_word(int s);
    logic [7:0] junk;
    junk = 8'($urandom);
    return {junk, 4'(s)};
  endfunction

  task automatic load_pixel(logic [7:0] y, logic [7:0] u, logic [7:0] v);
    yuv_pixel_t p;
    p.luma = y;
    p.cb   = u;
    p.cr   = v;
    pixel_feed.insert(pixel_feed.size(), p);
    pixels_loaded++;
  endtask

  task automatic load_edges(int count);
    for (int k = 0; k < count; k++) begin
      load_pixel(EDGE_VALUES[pixels_loaded % 8], EDGE_VALUES[(pixels_loaded + 3) % 8],
                 EDGE_VALUES[(pixels_loaded + 5) % 8]);
    end
  endtask

  function automatic logic [7:0] random_sample();
    if ($urandom_range(3) == 0) return EDGE_VALUES[$urandom_range(7)];
    return 8'($urandom_range(255));
  endfunction

  task automatic drain();
    do @(negedge clk);
    while (pixels_taken != pixels_loaded || pending_rgb.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic next_pace(ref int phase_no);
    pace = pace_t'(phase_no % 4);
    phase_no++;
  endtask

  initial begin : run_frames
    int phase_no, kind, n;
    phase_no   = 0;
    src_w_reg  = coord_t'(SRC_WIDTH_RESET);
    src_h_reg  = coord_t'(SRC_HEIGHT_RESET);
    dst_w_reg  = coord_t'(DST_WIDTH_RESET);
    dst_h_reg  = coord_t'(DST_HEIGHT_RESET);
    x_step_reg = step_t'(X_STEP_RESET);
    y_step_reg = step_t'(Y_STEP_RESET);
    col_pos = '0; row_pos = '0; kept_col = '0; kept_row = '0;
    col_phase = '0; row_phase = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // default geometry out of reset
    next_pace(phase_no);
    load_edges(6);
    drain();

    // zero sizes and steps behave as one, 1x1 output
    next_pace(phase_no);
    write_reg(REG_SRC_WIDTH, '0);
    write_reg(REG_SRC_HEIGHT, '0);
    write_reg(REG_X_STEP, step_word(0));
    write_reg(REG_Y_STEP, step_word(0));
    write_reg(REG_DST_WIDTH, 12'd1);
    write_reg(REG_DST_HEIGHT, 12'd1);
    close_writes();
    load_edges(4);
    drain();

    // zero output width keeps nothing
    next_pace(phase_no);
    write_reg(REG_DST_WIDTH, '0);
    close_writes();
    load_edges(3);
    drain();

    // output larger than the source
    next_pace(phase_no);
    write_reg(REG_SRC_WIDTH, 12'd3);
    write_reg(REG_SRC_HEIGHT, 12'd2);
    write_reg(REG_DST_WIDTH, 12'(MAX_COORD));
    write_reg(REG_DST_HEIGHT, 12'(MAX_COORD));
    write_reg(REG_X_STEP, step_word(1));
    write_reg(REG_Y_STEP, step_word(1));
    close_writes();
    load_edges(8);
    drain();

    // shrink mid-line, unused register slots
    next_pace(phase_no);
    write_reg(REG_SRC_WIDTH, 12'd2);
    write_reg(REG_X_STEP, step_word(3));
    write_reg(REG_SPARE_LO, 12'($urandom));
    write_reg(REG_SPARE_HI, 12'($urandom));
    close_writes();
    load_edges(4);
    drain();

    while (pixels_loaded < TARGET_PIXELS) begin
      next_pace(phase_no);
      kind = $urandom_range(9);
      n = $urandom_range(30, 80);
      if (kind == 0) begin
        write_reg(REG_SRC_WIDTH, 12'(MAX_COORD));
        write_reg(REG_X_STEP, step_word(MAX_STEP));
        write_reg(REG_DST_WIDTH, 12'(MAX_COORD));
        write_reg(REG_SRC_HEIGHT, 12'($urandom_range(1, 3)));
        write_reg(REG_DST_HEIGHT, 12'(MAX_COORD));
      end else if (kind == 1) begin
        write_reg(REG_SRC_WIDTH, 12'($urandom_range(0, 1)));
        write_reg(REG_SRC_HEIGHT, 12'(MAX_COORD));
        write_reg(REG_Y_STEP, step_word(MAX_STEP));
        write_reg(REG_DST_HEIGHT, 12'(MAX_COORD));
        write_reg(REG_DST_WIDTH, 12'($urandom_range(0, 2)));
      end else begin
        if ($urandom_range(4) != 0) write_reg(REG_SRC_WIDTH, 12'($urandom_range(0, 9)));
        if ($urandom_range(4) != 0) write_reg(REG_SRC_HEIGHT, 12'($urandom_range(0, 6)));
        if ($urandom_range(4) != 0) begin
          write_reg(REG_DST_WIDTH,
                    ($urandom_range(7) == 0) ? 12'(MAX_COORD) : 12'($urandom_range(0, 5)));
        end
        if ($urandom_range(4) != 0) begin
          write_reg(REG_DST_HEIGHT,
                    ($urandom_range(7) == 0) ? 12'(MAX_COORD) : 12'($urandom_range(0, 5)));
        end
        if ($urandom_range(4) != 0) begin
          write_reg(REG_X_STEP, step_word(($urandom_range(7) == 0) ? MAX_STEP :
                                          $urandom_range(0, 4)));
        end
        if ($urandom_range(4) != 0) begin
          write_reg(REG_Y_STEP, step_word(($urandom_range(7) == 0) ? MAX_STEP :
                                          $urandom_range(0, 4)));
        end
      end
      if ($urandom_range(3) == 0) begin
        write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, 12'($urandom));
      end
      close_writes();
      for (int k = 0; k < n; k++) begin
        load_pixel(random_sample(), random_sample(), random_sample());
      end
      drain();
    end

    if (fail_count == 0 && pending_rgb.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+src
src/yuvdec_pkg.sv
src/yuvdec_cfg.sv
src/yuvdec_raster.sv
src/yuvdec_convert.sv
src/yuv_decimate_to_rgb565.sv
bench/yuv_decimate_to_rgb565_tb.sv
